FILE: src/drf_pkg.sv
// Package for the deduplicating ring FIFO.
// Holds operation, status and sequencer codes and config register indexes.
// No dependencies.
package drf_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADLEN = 3'd1,
    ST_FULL   = 3'd2,
    ST_DUP    = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_HEAD,
    S_RESP
  } state_e;

  // Configuration register indexes
  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_MAX_LEN     = 1'b1;

  // Field widths fixed by the interface
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CAP_W-1:0] MAX_ENTRIES_RST = 5'd16;
  localparam logic [LEN_W-1:0] MAX_LEN_RST     = 4'd8;

endpackage

FILE: src/dedup_ring_fifo.sv
// Ring FIFO of short byte strings that rejects duplicate pushes.
// Entries live in one synchronous memory; a sequencer scans it per push.
// Depends on drf_pkg.
//
// Usage
//   Input channel: in_valid_i / in_stall_o with kind_i, push_data_i and
//   push_len_i. An item is taken when in_valid_i is high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i with status_o, head_data_o,
//   head_len_o, is_empty_o and is_full_o; exactly one result per item.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 max_entries, 1 max_len); write only while the block is idle.
// Sequence
//   Pop, peek and a rejected push (bad length or full) go through S_HEAD and
//   S_RESP to a loaded result, a push into an empty queue through S_WRITE
//   first. A push into a non-empty queue scans its entries, fifteen at most
//   since a push onto a full ring is refused: the scan reads one entry per
//   cycle through the single memory read port, then come a write and a head
//   read; a duplicate ends the scan without a write. One item is worked on at
//   a time; the next item is taken in the cycle after the result is loaded.
// Reset and stalls
//   Reset empties the queue and sets max_entries 16 and max_len 8; entry
//   storage is not cleared. The result sits in an output register: a new
//   item is accepted while it waits, but the following result is held back
//   inside the block until the receiver takes the pending one.
module dedup_ring_fifo #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned ENTRY_BYTES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [drf_pkg::CFG_W-1:0]         cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic [drf_pkg::DATA_W-1:0]        push_data_i,
  input  logic [drf_pkg::LEN_W-1:0]         push_len_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [drf_pkg::DATA_W-1:0]        head_data_o,
  output logic [drf_pkg::LEN_W-1:0]         head_len_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  localparam int unsigned DW   = 8 * ENTRY_BYTES;
  localparam int unsigned LW   = drf_pkg::LEN_W;
  localparam int unsigned MW   = DW + LW;
  localparam int unsigned PtrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [drf_pkg::CAP_W-1:0] max_entries_q;
  logic [LW-1:0]             max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= drf_pkg::MAX_ENTRIES_RST;
      max_len_q     <= drf_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        drf_pkg::CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i;
        drf_pkg::CFG_MAX_LEN:     max_len_q     <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // Capacity in use and length limit, clamped to the legal range
  logic [CntW-1:0] cap;
  logic [LW-1:0]   len_lim;

  always_comb begin
    if (max_entries_q == '0) begin
      cap = CntW'(1);
    end else if (32'(max_entries_q) > ENTRIES) begin
      cap = CntW'(ENTRIES);
    end else begin
      cap = CntW'(max_entries_q);
    end
    if (max_len_q == '0) begin
      len_lim = LW'(1);
    end else if (32'(max_len_q) > ENTRY_BYTES) begin
      len_lim = LW'(ENTRY_BYTES);
    end else begin
      len_lim = max_len_q;
    end
  end

  // Next slot with wrap at the capacity in use
  function automatic logic [PtrW-1:0] next_slot(logic [PtrW-1:0] p, logic [CntW-1:0] c);
    logic [CntW:0] n;
    n = (CntW+1)'(p) + (CntW+1)'(1);
    return (n >= (CntW+1)'(c)) ? '0 : PtrW'(n);
  endfunction

  // ---------------------------------------------------------------------------
  // State
  drf_pkg::state_e    state_q, state_d;
  logic [PtrW-1:0]    rptr_q, rptr_d;
  logic [PtrW-1:0]    wptr_q, wptr_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [PtrW-1:0]    scan_ptr_q, scan_ptr_d;
  logic [CntW-1:0]    scan_left_q, scan_left_d;
  logic               cmp_vld_q, cmp_vld_d;
  drf_pkg::status_e   op_status_q, op_status_d;
  logic [DW-1:0]      data_q, data_d;
  logic [LW-1:0]      len_q, len_d;

  // output register
  logic               out_valid_q, out_valid_d;
  drf_pkg::status_e   status_q, status_d;
  logic [drf_pkg::DATA_W-1:0] head_data_q, head_data_d;
  logic [LW-1:0]      head_len_q, head_len_d;
  logic               empty_q, empty_d;
  logic               full_q, full_d;

  // memory ports
  logic [MW-1:0]      mem_q [ENTRIES];
  logic [PtrW-1:0]    rd_addr;
  logic [MW-1:0]      rd_data_q;
  logic               wr_en;
  logic [PtrW-1:0]    wr_addr;

  // ---------------------------------------------------------------------------
  // Incoming push data with bytes beyond the length forced to zero
  logic [DW-1:0] data_masked;

  always_comb begin
    for (int b = 0; b < ENTRY_BYTES; b++) begin
      data_masked[8*b +: 8] = (LW'(b) < push_len_i) ? push_data_i[8*b +: 8] : 8'h00;
    end
  end

  // Compare of the scanned entry against the held push
  logic          match;
  logic [PtrW-1:0] wr_slot;
  logic          out_free;

  assign match    = (rd_data_q[MW-1:DW] == len_q) && (rd_data_q[DW-1:0] == data_q);
  assign wr_slot  = (CntW'(wptr_q) < cap) ? wptr_q : '0;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    fill_d      = fill_q;
    scan_ptr_d  = scan_ptr_q;
    scan_left_d = scan_left_q;
    cmp_vld_d   = 1'b0;
    op_status_d = op_status_q;
    data_d      = data_q;
    len_d       = len_q;
    rd_addr     = rptr_q;
    wr_en       = 1'b0;
    wr_addr     = wr_slot;

    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    head_data_d = head_data_q;
    head_len_d  = head_len_q;
    empty_d     = empty_q;
    full_d      = full_q;

    unique case (state_q)
      drf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          data_d      = data_masked;
          len_d       = push_len_i;
          op_status_d = drf_pkg::ST_OK;
          state_d     = drf_pkg::S_HEAD;
          case (kind_i)
            drf_pkg::KIND_PUSH: begin
              if (push_len_i == '0 || push_len_i > len_lim) begin
                op_status_d = drf_pkg::ST_BADLEN;
              end else if (fill_q >= cap) begin
                op_status_d = drf_pkg::ST_FULL;
              end else if (fill_q == '0) begin
                state_d = drf_pkg::S_WRITE;
              end else begin
                scan_ptr_d  = rptr_q;
                scan_left_d = fill_q;
                state_d     = drf_pkg::S_SCAN;
              end
            end
            drf_pkg::KIND_POP: begin
              if (fill_q == '0) begin
                op_status_d = drf_pkg::ST_EMPTY;
              end else begin
                rptr_d = next_slot(rptr_q, cap);
                fill_d = fill_q - CntW'(1);
              end
            end
            // peek, and the unused code that acts as one
            default: begin
              if (fill_q == '0) begin
                op_status_d = drf_pkg::ST_EMPTY;
              end
            end
          endcase
        end
      end

      // One read issued per cycle, compared in the next cycle
      drf_pkg::S_SCAN: begin
        rd_addr = scan_ptr_q;
        if (scan_left_q != '0) begin
          scan_ptr_d  = next_slot(scan_ptr_q, cap);
          scan_left_d = scan_left_q - CntW'(1);
          cmp_vld_d   = 1'b1;
        end
        if (cmp_vld_q && match) begin
          op_status_d = drf_pkg::ST_DUP;
          cmp_vld_d   = 1'b0;
          state_d     = drf_pkg::S_HEAD;
        end else if (scan_left_q == '0) begin
          cmp_vld_d = 1'b0;
          state_d   = drf_pkg::S_WRITE;
        end
      end

      drf_pkg::S_WRITE: begin
        wr_en   = 1'b1;
        wptr_d  = next_slot(wr_slot, cap);
        fill_d  = fill_q + CntW'(1);
        state_d = drf_pkg::S_HEAD;
      end

      // head read issued here, data valid in S_RESP
      drf_pkg::S_HEAD: begin
        state_d = drf_pkg::S_RESP;
      end

      drf_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = op_status_q;
          head_data_d = (fill_q != '0) ? drf_pkg::DATA_W'(rd_data_q[DW-1:0]) : '0;
          head_len_d  = (fill_q != '0) ? rd_data_q[MW-1:DW] : '0;
          empty_d     = (fill_q == '0);
          full_d      = (fill_q >= cap);
          state_d     = drf_pkg::S_IDLE;
        end
      end

      default: state_d = drf_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drf_pkg::S_IDLE;
      rptr_q      <= '0;
      wptr_q      <= '0;
      fill_q      <= '0;
      scan_ptr_q  <= '0;
      scan_left_q <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      fill_q      <= fill_d;
      scan_ptr_q  <= scan_ptr_d;
      scan_left_q <= scan_left_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_status_q <= op_status_d;
    data_q      <= data_d;
    len_q       <= len_d;
    status_q    <= status_d;
    head_data_q <= head_data_d;
    head_len_q  <= head_len_d;
    empty_q     <= empty_d;
    full_q      <= full_d;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {len_q, data_q};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Ports
  assign in_stall_o  = (state_q != drf_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign head_data_o = head_data_q;
  assign head_len_o  = head_len_q;
  assign is_empty_o  = empty_q;
  assign is_full_o   = full_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= ENTRIES)
    else $error("fill count above depth");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == drf_pkg::S_SCAN))
    else $error("compare pending outside scan");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drf_pkg::S_RESP && out_free) |=> out_valid_q)
    else $error("result not presented after response");

  a_pop_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drf_pkg::S_IDLE && in_valid_i && kind_i == drf_pkg::KIND_POP
     && fill_q != '0) |=> (fill_q == $past(fill_q) - CntW'(1)))
    else $error("pop did not remove one item");

endmodule

FILE: verif/dedup_ring_fifo_tb.sv
// Self-checking testbench for dedup_ring_fifo: directed ring fill, then random phases.
// Phases mix register settings and four idle patterns, checked against an in-bench model.
// Depends on drf_pkg and dedup_ring_fifo.
`timescale 1ns / 1ps

module dedup_ring_fifo_tb;

  // kind 3 has no enum member; the block treats it as a peek
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned SLOTS = 16;
  localparam int unsigned PHASES = 9;
  localparam int unsigned PHASE_ITEMS = 170;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] data;
    logic [3:0]  len;
  } op_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] data;
    logic [3:0]  len;
    logic        empty;
    logic        full;
  } fifo_view_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [63:0] push_data_i = '0;
  logic [3:0]  push_len_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] head_data_o;
  logic [3:0]  head_len_o;
  logic        is_empty_o;
  logic        is_full_o;

  dedup_ring_fifo u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .push_data_i(push_data_i),
    .push_len_i (push_len_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .head_data_o(head_data_o),
    .head_len_o (head_len_o),
    .is_empty_o (is_empty_o),
    .is_full_o  (is_full_o)
  );

  // Pending items, results still owed, idle pattern
  op_item_t    op_backlog[$];
  fifo_view_t  awaited[$];
  logic        item_on_bus = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  // Shadow of the ring and its registers
  logic [63:0] slot_data[SLOTS];
  logic [3:0]  slot_len[SLOTS];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  int unsigned fill = 0;
  logic [4:0]  cap_reg = drf_pkg::MAX_ENTRIES_RST;
  logic [3:0]  len_reg = drf_pkg::MAX_LEN_RST;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned cap_now();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  function automatic int unsigned len_limit();
    int unsigned l;
    l = len_reg;
    if (l < 1) l = 1;
    if (l > 8) l = 8;
    return l;
  endfunction

  function automatic int unsigned step_slot(input int unsigned p);
    return (p + 1 >= cap_now()) ? 0 : p + 1;
  endfunction

  // Keeps the low len bytes of an entry
  function automatic logic [63:0] byte_keep(input logic [3:0] len);
    if (len >= 8) return '1;
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  // Applies one item to the shadow ring and returns the result it yields
  function automatic fifo_view_t fifo_apply(input op_item_t it);
    fifo_view_t  r;
    logic [63:0] kept;
    int unsigned w;
    int unsigned p;
    int unsigned left;
    logic        found;
    r.status = drf_pkg::ST_OK;
    if (it.kind == drf_pkg::KIND_PUSH) begin
      if (it.len == 0 || it.len > len_limit()) begin
        r.status = drf_pkg::ST_BADLEN;
      end else if (fill >= cap_now()) begin
        r.status = drf_pkg::ST_FULL;
      end else begin
        kept = it.data & byte_keep(it.len);
        found = 1'b0;
        p = rd_ptr;
        for (left = fill; left != 0; left--) begin
          if (p < SLOTS && slot_len[p] == it.len && slot_data[p] == kept) found = 1'b1;
          p = step_slot(p);
        end
        if (found) begin
          r.status = drf_pkg::ST_DUP;
        end else begin
          w = (wr_ptr < cap_now()) ? wr_ptr : 0;
          slot_data[w] = kept;
          slot_len[w] = it.len;
          wr_ptr = step_slot(w);
          fill++;
        end
      end
    end else if (it.kind == drf_pkg::KIND_POP) begin
      if (fill == 0) begin
        r.status = drf_pkg::ST_EMPTY;
      end else begin
        rd_ptr = step_slot(rd_ptr);
        fill--;
      end
    end else if (fill == 0) begin
      r.status = drf_pkg::ST_EMPTY;
    end
    if (fill != 0 && rd_ptr < SLOTS) begin
      r.data = slot_data[rd_ptr];
      r.len = slot_len[rd_ptr];
    end else begin
      r.data = '0;
      r.len = '0;
    end
    r.empty = (fill == 0);
    r.full = (fill >= cap_now());
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_item(input logic [1:0] k, input logic [63:0] d,
                                     input logic [3:0] l);
    op_item_t it;
    it.kind = k;
    it.data = d;
    it.len = l;
    op_backlog.push_back(it);
  endfunction

  // Register write at a falling edge; the shadow copy follows
  task automatic write_reg(input logic idx, input logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == drf_pkg::CFG_MAX_ENTRIES) cap_reg = val;
    else len_reg = val[3:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (op_backlog.size() != 0 || awaited.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Sender and receiver, both driven on the falling edge
  always @(negedge clk_i) begin
    if (!item_on_bus) begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        kind_i <= op_backlog[0].kind;
        push_data_i <= op_backlog[0].data;
        push_len_i <= op_backlog[0].len;
        in_valid_i <= 1'b1;
        item_on_bus = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Item taken: work out its result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      awaited.push_back(fifo_apply(op_backlog[0]));
      void'(op_backlog.pop_front());
      item_on_bus = 1'b0;
    end
  end

  // Result taken: compare with the oldest owed result
  always @(posedge clk_i) begin : result_check
    fifo_view_t want;
    fifo_view_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, head_data_o, head_len_o, is_empty_o, is_full_o};
      if (awaited.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: status %0d data %h len %0d empty %b full %b",
                   got.status, got.data, got.len, got.empty, got.full);
        mismatch_count++;
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status || got.data !== want.data ||
            got.len !== want.len || got.empty !== want.empty || got.full !== want.full) begin
          if (mismatch_count < 10)
            $display({"mismatch at %0t: exp st %0d data %h len %0d e %b f %b,",
                      " got st %0d data %h len %0d e %b f %b"},
                     $realtime, want.status, want.data, want.len, want.empty, want.full,
                     got.status, got.data, got.len, got.empty, got.full);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned caps[PHASES];
    int unsigned lens[PHASES];
    op_item_t    pool[$];
    op_item_t    src;
    logic [63:0] d;
    logic [63:0] keep;
    logic [3:0]  l;
    logic [1:0]  k;
    logic        push_heavy;
    int unsigned ph;
    int unsigned n;
    int unsigned i;
    int unsigned roll;

    caps = '{16, 1, 0, 31, 5, 16, 3, 12, 2};
    lens = '{8, 1, 0, 15, 3, 8, 8, 2, 5};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue: peek, pop, spare kind, lengths zero and above the limit
    queue_item(drf_pkg::KIND_PEEK, rand64(), 4'd3);
    queue_item(drf_pkg::KIND_POP, rand64(), 4'd0);
    queue_item(KIND_SPARE, rand64(), 4'd8);
    queue_item(drf_pkg::KIND_PUSH, rand64(), 4'd0);
    queue_item(drf_pkg::KIND_PUSH, rand64(), 4'd9);
    // Fill every slot once with distinct entries; garbage above the length
    for (i = 0; i < SLOTS; i++) begin
      d = rand64();
      d[7:0] = 8'(i);
      if (i == 1) d[15:0] = '0;  // same bytes as entry 0, longer length
      if (i == 7) d = '1;
      queue_item(drf_pkg::KIND_PUSH, d, 4'((i % 8) + 1));
      if (i == 2) begin
        // repeat of entry 1 with other high bytes: duplicate
        d = rand64();
        d[15:0] = '0;
        queue_item(drf_pkg::KIND_PUSH, d, 4'd2);
      end
    end
    // Full ring: length check wins over full, full wins over duplicate
    queue_item(drf_pkg::KIND_PUSH, rand64(), 4'd3);
    queue_item(drf_pkg::KIND_PUSH, rand64(), 4'd15);
    queue_item(drf_pkg::KIND_PUSH, '1, 4'd8);
    queue_item(drf_pkg::KIND_PEEK, rand64(), 4'd1);
    queue_item(KIND_SPARE, rand64(), 4'd5);
    wait_drained();

    // Random phases, each with a setting from the table and one of four idle patterns in turn
    push_heavy = 1'b1;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_reg(drf_pkg::CFG_MAX_ENTRIES, 5'(caps[ph]));
      write_reg(drf_pkg::CFG_MAX_LEN, 5'(lens[ph]));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // pick fill or drain stretches at random so both full and empty come up
        if (n % 24 == 0) push_heavy = 1'($urandom_range(1));
        roll = $urandom_range(99);
        d = rand64();
        l = 4'($urandom_range(15));
        if (roll < 8) begin
          k = drf_pkg::KIND_PEEK;
        end else if (roll < 11) begin
          k = KIND_SPARE;
        end else if (roll < (push_heavy ? 75 : 40)) begin
          k = drf_pkg::KIND_PUSH;
          if ($urandom_range(99) >= 12) l = 4'($urandom_range(len_limit(), 1));
          if (pool.size() != 0 && $urandom_range(99) < 30) begin
            // reuse an earlier entry with fresh bytes above its length
            src = pool[$urandom_range(pool.size() - 1)];
            l = src.len;
            keep = byte_keep(l);
            d = (src.data & keep) | (d & ~keep);
          end
          if (l >= 1 && l <= 8) begin
            src.kind = drf_pkg::KIND_PUSH;
            src.data = d;
            src.len = l;
            pool.push_back(src);
            if (pool.size() > 24) void'(pool.pop_front());
          end
        end else begin
          k = drf_pkg::KIND_POP;
        end
        queue_item(k, d, l);
      end
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("dedup_ring_fifo test passed");
    end else begin
      $display("dedup_ring_fifo test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("dedup_ring_fifo test failed");
    $finish;
  end

endmodule
